// File: rtl/core/lrdc_pkg.sv
// ----------------------------------------------------------------------------
// Log record deframer package
// Shared types, result kinds, error codes and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package lrdc_pkg;

    localparam int unsigned HdrBytes   = 23;
    localparam int unsigned CrcBytes   = 4;
    localparam logic [31:0] CrcPoly    = 32'hEDB88320;
    localparam logic [31:0] AllOnes    = 32'hFFFFFFFF;
    localparam logic [20:0] LimitReset = 21'(1024 * 1024);
    localparam int unsigned QueueDepth = 4;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;
    localparam logic [1:0] KIND_EOL     = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_CRC      = 3'd3;
    localparam logic [2:0] ERR_TRUNC    = 3'd4;

    localparam logic CFG_MAGIC = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    // One result word: kind, payload byte, header fields, error, count, last.
    typedef struct packed {
        logic        last;
        logic [31:0] accepted_count;
        logic [2:0]  error_code;
        logic [20:0] payload_length;
        logic [31:0] object_number;
        logic [15:0] object_kind;
        logic [7:0]  op_code;
        logic [63:0] tx_id;
        logic [7:0]  payload_byte;
        logic [1:0]  kind;
    } t_result;

    // Classified input byte with the up to three results it causes.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_entry;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int j = 0; j < 8; j++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// File: rtl/core/lrdc_front.sv
// ----------------------------------------------------------------------------
// Log record deframer front end
// Parses headers, runs the CRCs and builds the results each byte causes.
// ----------------------------------------------------------------------------
module lrdc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_eol,
    output lrdc_pkg::t_entry  o_entry
);
    import lrdc_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_CHECK   = 3'b100
    } t_phase;

    logic [31:0] r_magic_cfg;
    logic [20:0] r_limit;
    t_phase      r_phase, n_phase;
    logic [20:0] r_idx, n_idx;
    logic [31:0] r_hmagic, n_hmagic;
    logic [63:0] r_tx, n_tx;
    logic [7:0]  r_op, n_op;
    logic [15:0] r_okind, n_okind;
    logic [31:0] r_onum, n_onum;
    logic [31:0] r_len, n_len;
    logic [31:0] r_hcrc, n_hcrc;
    logic [31:0] r_pcrc, n_pcrc;
    logic [31:0] r_scrc, n_scrc;
    logic [31:0] r_count, n_count;
    logic        r_halted, n_halted;

    t_result     res [3];
    logic [1:0]  cnt;
    logic [31:0] calc;
    logic [4:0]  hi;

    function automatic t_result mk(input logic [1:0] k, input logic [7:0] pb,
                                   input logic [2:0] e, input logic [63:0] tx,
                                   input logic [7:0] op, input logic [15:0] ok,
                                   input logic [31:0] on, input logic [31:0] ln,
                                   input logic [31:0] ac);
        t_result r;
        logic    rec;
        rec = (k != KIND_EOL);
        r.kind           = k;
        r.payload_byte   = pb;
        r.tx_id          = rec ? tx : 64'd0;
        r.op_code        = rec ? op : 8'd0;
        r.object_kind    = rec ? ok : 16'd0;
        r.object_number  = rec ? on : 32'd0;
        r.payload_length = rec ? ln[20:0] : 21'd0;
        r.error_code     = e;
        r.accepted_count = ac;
        r.last           = 1'b0;
        return r;
    endfunction

    always_comb begin
        n_phase = r_phase;   n_idx = r_idx;     n_hmagic = r_hmagic;
        n_tx = r_tx;         n_op = r_op;       n_okind = r_okind;
        n_onum = r_onum;     n_len = r_len;     n_hcrc = r_hcrc;
        n_pcrc = r_pcrc;     n_scrc = r_scrc;   n_count = r_count;
        n_halted = r_halted;
        cnt = 2'd0;
        res[0] = '0; res[1] = '0; res[2] = '0;
        calc = '0;
        hi = r_idx[4:0];
        if (!r_halted) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_idx == 21'd0) begin
                        n_hmagic = '0; n_tx = '0; n_op = '0; n_okind = '0;
                        n_onum = '0; n_len = '0; n_hcrc = AllOnes;
                        n_pcrc = AllOnes; n_scrc = '0;
                    end
                    n_hcrc = crc_byte(n_hcrc, i_byte);
                    if (hi < 5'd4)       n_hmagic[8*hi[1:0] +: 8] = i_byte;
                    else if (hi < 5'd12) n_tx[8*(3'(hi - 5'd4)) +: 8] = i_byte;
                    else if (hi == 5'd12) n_op = i_byte;
                    else if (hi < 5'd15) n_okind[8*(1'(hi - 5'd13)) +: 8] = i_byte;
                    else if (hi < 5'd19) n_onum[8*(2'(hi - 5'd15)) +: 8] = i_byte;
                    else                 n_len[8*(2'(hi - 5'd19)) +: 8] = i_byte;
                    n_idx = r_idx + 21'd1;
                    if (n_idx >= 21'(HdrBytes)) begin
                        n_idx = '0;
                        if (n_hmagic != r_magic_cfg) begin
                            res[0] = mk(KIND_REJECT, 8'd0, ERR_MAGIC, n_tx, n_op,
                                        n_okind, n_onum, n_len, n_count);
                            cnt = 2'd1; n_halted = 1'b1;
                        end else if (n_len > {11'd0, r_limit}) begin
                            res[0] = mk(KIND_REJECT, 8'd0, ERR_LENGTH, n_tx, n_op,
                                        n_okind, n_onum, n_len, n_count);
                            cnt = 2'd1; n_halted = 1'b1;
                        end else begin
                            n_phase = (n_len != 32'd0) ? PH_PAYLOAD : PH_CHECK;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_pcrc = crc_byte(r_pcrc, i_byte);
                    res[0] = mk(KIND_PAYLOAD, i_byte, ERR_NONE, r_tx, r_op,
                                r_okind, r_onum, r_len, r_count);
                    cnt = 2'd1;
                    n_idx = r_idx + 21'd1;
                    if ({11'd0, n_idx} >= r_len) begin
                        n_idx = '0; n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_scrc[8*r_idx[1:0] +: 8] = i_byte;
                    n_idx = r_idx + 21'd1;
                    if (n_idx >= 21'(CrcBytes)) begin
                        n_idx = '0; n_phase = PH_HEADER;
                        calc = ~r_hcrc ^ ((r_len != 32'd0) ? ~r_pcrc : 32'd0);
                        if (calc == n_scrc) begin
                            n_count = r_count + 32'd1;
                            res[0] = mk(KIND_ACCEPT, 8'd0, ERR_NONE, r_tx, r_op,
                                        r_okind, r_onum, r_len, n_count);
                        end else begin
                            res[0] = mk(KIND_REJECT, 8'd0, ERR_CRC, r_tx, r_op,
                                        r_okind, r_onum, r_len, r_count);
                            n_halted = 1'b1;
                        end
                        cnt = 2'd1;
                    end
                end
                default: n_phase = PH_HEADER;
            endcase
        end
        if (i_eol) begin
            if (!n_halted && (n_phase != PH_HEADER || n_idx != 21'd0)) begin
                res[cnt] = mk(KIND_REJECT, 8'd0, ERR_TRUNC, n_tx, n_op,
                              n_okind, n_onum, n_len, n_count);
                cnt = cnt + 2'd1;
            end
            res[cnt] = mk(KIND_EOL, 8'd0, ERR_NONE, '0, '0, '0, '0, '0, n_count);
            cnt = cnt + 2'd1;
            n_phase = PH_HEADER; n_idx = '0; n_hmagic = '0; n_tx = '0;
            n_op = '0; n_okind = '0; n_onum = '0; n_len = '0;
            n_hcrc = AllOnes; n_pcrc = AllOnes; n_scrc = '0;
            n_count = '0; n_halted = 1'b0;
        end
        if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
        o_entry.count = cnt;
        o_entry.r0 = res[0];
        o_entry.r1 = res[1];
        o_entry.r2 = res[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_cfg <= '0;
            r_limit     <= LimitReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAGIC) r_magic_cfg <= i_cfg_data;
            else                        r_limit     <= i_cfg_data[20:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_idx <= '0; r_hmagic <= '0; r_tx <= '0;
            r_op <= '0; r_okind <= '0; r_onum <= '0; r_len <= '0;
            r_hcrc <= AllOnes; r_pcrc <= AllOnes; r_scrc <= '0;
            r_count <= '0; r_halted <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_idx <= n_idx; r_hmagic <= n_hmagic;
            r_tx <= n_tx; r_op <= n_op; r_okind <= n_okind; r_onum <= n_onum;
            r_len <= n_len; r_hcrc <= n_hcrc; r_pcrc <= n_pcrc;
            r_scrc <= n_scrc; r_count <= n_count; r_halted <= n_halted;
        end
    end

endmodule

// File: rtl/core/lrdc_back.sv
// ----------------------------------------------------------------------------
// Log record deframer back end
// Queues classified bytes and plays out their results one word at a time.
// ----------------------------------------------------------------------------
module lrdc_back #(
    parameter int unsigned DEPTH = lrdc_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lrdc_pkg::t_entry  i_entry,
    output logic              o_ready,
    output logic              o_valid,
    output lrdc_pkg::t_result o_result,
    input  logic              i_ready
);
    import lrdc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_entry           r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_fill;
    logic [1:0]       r_sub;
    t_entry           head;
    logic             pop, take, push_eff;

    assign head     = r_mem[r_rp];
    assign o_valid  = (r_fill != '0);
    assign o_result = (r_sub == 2'd0) ? head.r0 : (r_sub == 2'd1) ? head.r1 : head.r2;
    assign take     = o_valid && i_ready;
    assign pop      = take && (r_sub + 2'd1 == head.count);
    assign push_eff = i_push && (i_entry.count != 2'd0);
    assign o_ready  = (r_fill < (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (push_eff) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_fill <= '0; r_sub <= '0;
        end else begin
            if (push_eff) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop) begin
                r_rp  <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
                r_sub <= '0;
            end else if (take) begin
                r_sub <= r_sub + 2'd1;
            end
            r_fill <= r_fill + (AW+1)'(push_eff) - (AW+1)'(pop);
        end
    end

endmodule

// File: rtl/core/log_record_deframer_checker_core.sv
// ----------------------------------------------------------------------------
// Log record deframer and checker
// Splits a log byte stream into records, checks each against its CRC-32.
// ----------------------------------------------------------------------------
// Input words carry one log byte and an end-of-log flag in tlast. Each word
// yields up to three output words: payload bytes are passed straight on, and
// a record ends with an accept or reject word; end of log adds a word that
// carries the accepted count. The output kind travels in tuser, and tlast
// marks the final word per input.
// The front end classifies one byte per cycle while the queue has room and
// writes the results into a four-deep queue; the back end plays them out one
// word per cycle while the receiver is ready. Results pass through the queue
// registers before they reach the output. Throughput is one input word per
// cycle while outputs flow, limited by the single output word per cycle when
// a byte causes more than one result. When the receiver stalls the queue
// fills and s_axis_tready drops. Reset clears the parser, the queue and the
// registers (magic 0, payload limit 1 MiB). Write configuration only while idle.
// ----------------------------------------------------------------------------
module log_record_deframer_checker_core #(
    parameter int unsigned QUEUE_DEPTH = lrdc_pkg::QueueDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // log_byte
    input  logic         s_axis_tlast,   // end_of_log
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // payload_byte, tx_id, op_code, object_kind, object_number,
    // payload_length, error_code, accepted_count
    output logic [183:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last
);
    import lrdc_pkg::*;

    t_entry  entry;
    t_result res;
    logic    acc;

    assign acc = s_axis_tvalid && s_axis_tready;

    lrdc_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(acc), .i_byte(s_axis_tdata), .i_eol(s_axis_tlast),
        .o_entry(entry)
    );

    lrdc_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_push(acc), .i_entry(entry),
        .o_ready(s_axis_tready), .o_valid(m_axis_tvalid),
        .o_result(res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {res.accepted_count, res.error_code,
                           res.payload_length, res.object_number,
                           res.object_kind, res.op_code, res.tx_id,
                           res.payload_byte};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.kind == KIND_EOL |-> m_axis_tlast)
        else $error("end-of-log word without tlast");
    a_err_only_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.kind != KIND_REJECT |-> res.error_code == ERR_NONE)
        else $error("error code on non-reject word");
    a_eol_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tlast |-> entry.count != 2'd0)
        else $error("end of log produced no result");

endmodule

// File: tb/sv/log_record_deframer_checker_core_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Log record deframer checker monitor
// Watches the configuration port and both streams, predicts the output words
// of every accepted log byte and compares them in order with the block.
// ----------------------------------------------------------------------------
module log_record_deframer_checker_core_chk
    import lrdc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [183:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           o_fail_count,
    output int           o_pending
);

    typedef enum logic [1:0] {PH_HDR, PH_PAY, PH_CHK} t_phase;

    t_result     want_q[$];
    logic [31:0] magic_reg;
    logic [20:0] limit_reg;
    t_phase      ph;
    logic [31:0] idx;
    logic [31:0] hdr_magic;
    logic [63:0] hdr_tx;
    logic [7:0]  hdr_op;
    logic [15:0] hdr_okind;
    logic [31:0] hdr_onum;
    logic [31:0] hdr_len;
    logic [31:0] crc_h;
    logic [31:0] crc_p;
    logic [31:0] crc_stored;
    logic [31:0] n_accepted;
    logic        stopped;
    int          n_new;

    assign o_pending = want_q.size();

    function automatic logic [31:0] crc8(logic [31:0] c_in, logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    task automatic clear_log();
        ph = PH_HDR; idx = 0; hdr_magic = 0; hdr_tx = 0; hdr_op = 0;
        hdr_okind = 0; hdr_onum = 0; hdr_len = 0; crc_h = '1; crc_p = '1;
        crc_stored = 0; n_accepted = 0; stopped = 0;
    endtask

    task automatic push_word(logic [1:0] k, logic [7:0] pb, logic [2:0] err);
        t_result r;
        logic    rec;
        rec = (k != KIND_EOL);
        r = '0;
        r.kind = k;
        r.payload_byte = pb;
        r.tx_id = rec ? hdr_tx : '0;
        r.op_code = rec ? hdr_op : '0;
        r.object_kind = rec ? hdr_okind : '0;
        r.object_number = rec ? hdr_onum : '0;
        r.payload_length = rec ? hdr_len[20:0] : '0;
        r.error_code = err;
        r.accepted_count = n_accepted;
        want_q.push_back(r);
        n_new++;
    endtask

    task automatic reject_record(logic [2:0] err);
        push_word(KIND_REJECT, 8'd0, err);
        stopped = 1; ph = PH_HDR; idx = 0;
    endtask

    task automatic predict_byte(logic [7:0] b, logic eol);
        logic [31:0] calc;
        n_new = 0;
        if (!stopped) begin
            case (ph)
                PH_HDR: begin
                    if (idx == 0) begin
                        hdr_magic = 0; hdr_tx = 0; hdr_op = 0; hdr_okind = 0;
                        hdr_onum = 0; hdr_len = 0; crc_h = '1; crc_p = '1;
                        crc_stored = 0;
                    end
                    crc_h = crc8(crc_h, b);
                    if (idx < 4) hdr_magic[8*idx +: 8] = b;
                    else if (idx < 12) hdr_tx[8*(idx-4) +: 8] = b;
                    else if (idx == 12) hdr_op = b;
                    else if (idx < 15) hdr_okind[8*(idx-13) +: 8] = b;
                    else if (idx < 19) hdr_onum[8*(idx-15) +: 8] = b;
                    else hdr_len[8*(idx-19) +: 8] = b;
                    idx++;
                    if (idx >= HdrBytes) begin
                        idx = 0;
                        if (hdr_magic != magic_reg) reject_record(ERR_MAGIC);
                        else if (hdr_len > {11'd0, limit_reg}) reject_record(ERR_LENGTH);
                        else ph = (hdr_len != 0) ? PH_PAY : PH_CHK;
                    end
                end
                PH_PAY: begin
                    crc_p = crc8(crc_p, b);
                    push_word(KIND_PAYLOAD, b, ERR_NONE);
                    idx = (idx + 1) & 32'h1FFFFF;
                    if (idx >= hdr_len) begin
                        idx = 0; ph = PH_CHK;
                    end
                end
                default: begin
                    crc_stored[8*idx[1:0] +: 8] = b;
                    idx++;
                    if (idx >= CrcBytes) begin
                        idx = 0; ph = PH_HDR;
                        calc = ~crc_h;
                        if (hdr_len != 0) calc ^= ~crc_p;
                        if (calc == crc_stored) begin
                            n_accepted++;
                            push_word(KIND_ACCEPT, 8'd0, ERR_NONE);
                        end else begin
                            reject_record(ERR_CRC);
                        end
                    end
                end
            endcase
        end
        if (eol) begin
            if (!stopped && (ph != PH_HDR || idx != 0)) reject_record(ERR_TRUNC);
            push_word(KIND_EOL, 8'd0, ERR_NONE);
            clear_log();
        end
        if (n_new > 0) want_q[$].last = 1'b1;
    endtask

    task automatic compare_word(t_result got);
        t_result w;
        if (want_q.size() == 0) begin
            $error("unexpected output word %h", got);
            o_fail_count++;
            return;
        end
        w = want_q.pop_front();
        if (got.kind !== w.kind) begin
            $error("kind: expected %0d actual %0d", w.kind, got.kind); o_fail_count++;
        end
        if (got.payload_byte !== w.payload_byte) begin
            $error("payload_byte: expected %0h actual %0h", w.payload_byte, got.payload_byte);
            o_fail_count++;
        end
        if (got.tx_id !== w.tx_id) begin
            $error("tx_id: expected %0h actual %0h", w.tx_id, got.tx_id); o_fail_count++;
        end
        if (got.op_code !== w.op_code) begin
            $error("op_code: expected %0h actual %0h", w.op_code, got.op_code); o_fail_count++;
        end
        if (got.object_kind !== w.object_kind) begin
            $error("object_kind: expected %0h actual %0h", w.object_kind, got.object_kind);
            o_fail_count++;
        end
        if (got.object_number !== w.object_number) begin
            $error("object_number: expected %0h actual %0h", w.object_number,
                   got.object_number);
            o_fail_count++;
        end
        if (got.payload_length !== w.payload_length) begin
            $error("payload_length: expected %0d actual %0d", w.payload_length,
                   got.payload_length);
            o_fail_count++;
        end
        if (got.error_code !== w.error_code) begin
            $error("error_code: expected %0d actual %0d", w.error_code, got.error_code);
            o_fail_count++;
        end
        if (got.accepted_count !== w.accepted_count) begin
            $error("accepted_count: expected %0d actual %0d", w.accepted_count,
                   got.accepted_count);
            o_fail_count++;
        end
        if (got.last !== w.last) begin
            $error("last: expected %0b actual %0b", w.last, got.last); o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        magic_reg = 0;
        limit_reg = LimitReset;
        clear_log();
    end

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            magic_reg = 0;
            limit_reg = LimitReset;
            clear_log();
            want_q.delete();
        end else begin
            // Output first: a word leaving now can never be one caused this edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata, m_axis_tuser};
                compare_word(got);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAGIC) magic_reg = i_cfg_data;
                else limit_reg = i_cfg_data[20:0];
            end
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
        end
    end

endmodule

// File: tb/sv/log_record_deframer_checker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Log record deframer testbench
// Builds logs of well-formed records with random content, mixed with corrupt
// headers, bad check values, truncation and noise, under varied flow control.
// A separate monitor predicts and checks every output word.
// ----------------------------------------------------------------------------
module log_record_deframer_checker_core_tb;
    import lrdc_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [183:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           n_sent;
    logic [31:0]  cur_magic;
    logic [7:0]   rec_bytes[$];

    log_record_deframer_checker_core dut (.*);

    log_record_deframer_checker_core_chk u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !i_rst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] crc8(logic [31:0] c_in, logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    // Sends one log byte, holding valid until it is taken. Valid stays high
    // after the handshake so that words can follow back to back.
    task automatic send_word(logic [7:0] b, logic eol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eol;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
    endtask

    // Builds one record. Corruption: 0 none, 1 magic, 2 check value.
    task automatic build_record(logic [31:0] magic, int plen, int corrupt, logic [63:0] tx);
        logic [31:0] ch;
        logic [31:0] cp;
        logic [31:0] chk;
        logic [7:0]  b;
        rec_bytes.delete();
        for (int i = 0; i < 4; i++) rec_bytes.push_back(magic[8*i +: 8]);
        for (int i = 0; i < 8; i++) rec_bytes.push_back(tx[8*i +: 8]);
        for (int i = 0; i < 7; i++) rec_bytes.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) rec_bytes.push_back(8'(plen >> (8*i)));
        if (corrupt == 1) rec_bytes[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        ch = '1;
        foreach (rec_bytes[i]) ch = crc8(ch, rec_bytes[i]);
        cp = '1;
        for (int i = 0; i < plen; i++) begin
            b = 8'($urandom);
            cp = crc8(cp, b);
            rec_bytes.push_back(b);
        end
        chk = ~ch;
        if (plen != 0) chk ^= ~cp;
        if (corrupt == 2) chk ^= 32'(1) << $urandom_range(31);
        for (int i = 0; i < 4; i++) rec_bytes.push_back(chk[8*i +: 8]);
    endtask

    // Sends the current record; cut stops after that many bytes and ends the log.
    task automatic send_record(int cut, logic eol_at_end);
        int n;
        n = (cut > 0 && cut < rec_bytes.size()) ? cut : rec_bytes.size();
        for (int i = 0; i < n; i++)
            send_word(rec_bytes[i], (i == n - 1) && (eol_at_end || n != rec_bytes.size()));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MAGIC) cur_magic = val;
    endtask

    task automatic random_phase(int n_items, int limit);
        int r;
        int plen;
        while (n_sent < n_items) begin
            r = $urandom_range(99);
            plen = ($urandom_range(9) == 0) ? $urandom_range(limit < 40 ? limit : 40)
                                            : $urandom_range(limit < 6 ? limit : 6);
            if (r < 70) begin
                build_record(cur_magic, plen, 0, {$urandom, $urandom});
                send_record(0, $urandom_range(3) == 0);
            end else if (r < 78) begin
                build_record(cur_magic, plen, 1 + $urandom_range(1), {$urandom, $urandom});
                send_record(0, 1'b0);
                send_word(8'($urandom), 1'b1);
            end else if (r < 86) begin
                build_record(cur_magic, plen, 0, {$urandom, $urandom});
                send_record(1 + $urandom_range(rec_bytes.size() - 2), 1'b1);
            end else if (r < 92) begin
                build_record(cur_magic, limit + 1 + $urandom_range(3), 0, {$urandom, $urandom});
                send_record(23, 1'b0);
                send_word(8'($urandom), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) send_word(8'($urandom), 1'b0);
                send_word(8'($urandom), 1'b1);
            end
        end
        send_word(8'($urandom), 1'b1);
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_MAGIC;
        i_cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_sent = 0;
        cur_magic = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default magic of zero, all-ones and empty payloads, truncation.
        build_record(32'h0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_record(0, 1'b0);
        build_record(32'h0, 2, 0, 64'h0);
        send_record(0, 1'b1);
        build_record(32'h0, 3, 2, 64'h1);
        send_record(0, 1'b1);
        build_record(32'h0, 1, 0, 64'h2);
        send_record(10, 1'b1);
        drain();

        write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_LIMIT, 32'h0);
        build_record(32'hFFFF_FFFF, 0, 0, 64'h8000_0000_0000_0000);
        send_record(0, 1'b0);
        build_record(32'hFFFF_FFFF, 1, 0, 64'h3);
        send_record(23, 1'b0);
        send_word(8'hFF, 1'b1);
        build_record(32'hFFFF_FFFF, 0, 1, 64'h4);
        send_record(0, 1'b1);
        drain();

        write_reg(CFG_MAGIC, 32'h5741_4C31);
        write_reg(CFG_LIMIT, 32'hFFE0_0000 | 32'd12);
        random_phase(180, 12);
        drain();

        send_idle_pct = 79;
        write_reg(CFG_LIMIT, 32'h0010_0000);
        random_phase(300, 64);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 79;
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_LIMIT, 32'h001F_FFFF);
        random_phase(420, 40);
        drain();

        send_idle_pct = 21;
        recv_stall_pct = 21;
        write_reg(CFG_LIMIT, 32'd7);
        random_phase(520, 7);
        drain();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
